// ===== rtl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam int MaxRegions = 64;
    localparam int Alignment = 8;
    localparam int IdxW = $clog2(MaxRegions);
    localparam int CntW = $clog2(MaxRegions + 1);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE = 2'd1;
    localparam logic [1:0] CMD_STATS = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_NOMEM = 3'd3;
    localparam logic [2:0] ST_DOUBLE = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_END = 1'b1;

    // One table entry.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic used;
    } region_t;

    // Round up to the alignment; the extra top bit flags a wrap.
    function automatic logic [32:0] round_up(input logic [31:0] v);
        logic [32:0] s;
        logic [32:0] mask;
        begin
            mask = ~(33'(Alignment) - 33'd1);
            s = {1'b0, v} + 33'(Alignment - 1);
            round_up = s & mask;
        end
    endfunction

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
// First-fit allocator top level: sequencer, shared adder and region table.
// Depends on ffba_pkg and ffba_table.
//
// A command is taken when start is high and busy is low; busy then stays high
// through the cycle in which its single result beat shows on done. The table
// sits in one single-port-write, registered-read memory, so each command walks
// it entry by entry: a search pass, an optional shift pass for a split or
// merge, and a statistics pass, each through the memory port. Search and shift
// together cover the table at most once. The first command after reset loads
// the heap region. Results cannot be stalled; the receiver must take every beat.
module first_fit_block_allocator_core (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [31:0] cfg_data,
    input  logic start,
    output logic busy,
    input  logic [1:0] command,
    input  logic [31:0] request_size,
    input  logic [31:0] block_address,
    output logic done,
    output logic [31:0] result_address,
    output logic [2:0] status,
    output logic [31:0] free_total,
    output logic [31:0] used_total,
    output logic [6:0] block_count
);

    localparam int IW = ffba_pkg::IdxW;
    localparam int CW = ffba_pkg::CntW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_SRCH = 4'd2;
    localparam logic [3:0] S_SHUP = 4'd3;
    localparam logic [3:0] S_SHUPW = 4'd4;
    localparam logic [3:0] S_SHDN = 4'd5;
    localparam logic [3:0] S_SHDNW = 4'd6;
    localparam logic [3:0] S_FREE2 = 4'd7;
    localparam logic [3:0] S_FREE3 = 4'd8;
    localparam logic [3:0] S_STAT = 4'd9;
    localparam logic [3:0] S_STATW = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;
    localparam logic [3:0] S_FREE4 = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [31:0] hs_reg, he_reg;
    logic init_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;   // current read index
    logic [IW-1:0] hit_reg, hit_next;   // found entry
    logic [CW-1:0] lim_reg, lim_next;   // shift end
    logic [1:0] cmd_reg;
    logic [31:0] want_reg, addr_reg, raddr_reg, raddr_next;
    logic [2:0] st_reg, st_next;
    logic [31:0] fsum_reg, fsum_next, usum_reg, usum_next;
    logic [31:0] acc_reg, acc_next;     // merged size
    logic mergeprev_reg, mergeprev_next;
    ffba_pkg::region_t prev_reg, prev_next, hold_reg, hold_next;

    logic we;
    logic [IW-1:0] waddr, raddr;
    ffba_pkg::region_t wdata, rd;
    logic [32:0] want_w, hs_w;
    logic [31:0] add_a, add_b, add_y;   // shared adder

    logic init_we;
    ffba_pkg::region_t init_entry;
    logic [3:0] first_state;
    logic [2:0] first_status;
    logic we_m;
    logic [IW-1:0] waddr_m;
    ffba_pkg::region_t wdata_m;

    ffba_table u_table (
        .clk(clk), .we(we_m), .waddr(waddr_m), .wdata(wdata_m),
        .raddr(raddr), .rdata(rd)
    );

    assign add_y = add_a + add_b;
    assign want_w = ffba_pkg::round_up(request_size);
    assign hs_w = ffba_pkg::round_up(hs_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg <= 32'h4000_0000;
            he_reg <= 32'h5000_0000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ffba_pkg::REG_HEAP_START)
            begin
                hs_reg <= cfg_data;
            end
            else
            begin
                he_reg <= cfg_data;
            end
        end
    end

    // Route the initial load and the idle-time decision onto the sequencer.
    assign init_entry = '{start: hs_w[31:0],
                          size: (he_reg >= hs_w[31:0]) ? he_reg - hs_w[31:0] : 32'd0,
                          used: 1'b0};
    assign init_we = (state_reg == S_IDLE) && start && !init_reg;

    always_comb
    begin
        first_state = S_STAT;
        first_status = ffba_pkg::ST_OK;
        if (command == ffba_pkg::CMD_ALLOC && request_size == 32'd0)
        begin
            first_status = ffba_pkg::ST_ZERO;
        end
        else if (command == ffba_pkg::CMD_ALLOC && want_w[32])
        begin
            first_status = ffba_pkg::ST_OVERFLOW;
        end
        else if (command == ffba_pkg::CMD_ALLOC)
        begin
            first_state = S_RD;
        end
        else if (command == ffba_pkg::CMD_FREE && block_address != 32'd0)
        begin
            first_state = S_RD;
        end
    end

    assign we_m = init_we ? 1'b1 : we;
    assign waddr_m = init_we ? '0 : waddr;
    assign wdata_m = init_we ? init_entry : wdata;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        lim_next = lim_reg;
        raddr_next = raddr_reg;
        st_next = st_reg;
        fsum_next = fsum_reg;
        usum_next = usum_reg;
        acc_next = acc_reg;
        mergeprev_next = mergeprev_reg;
        prev_next = prev_reg;
        hold_next = hold_reg;
        we = 1'b0;
        waddr = idx_reg;
        wdata = rd;
        raddr = idx_reg;
        add_a = acc_reg;
        add_b = rd.size;
        unique case (state_reg)
            S_IDLE:
            begin
                raddr = '0;
                if (start)
                begin
                    // Take the command beat and clear the per-command state.
                    state_next = first_state;
                    idx_next = '0;
                    raddr_next = '0;
                    st_next = first_status;
                    fsum_next = '0;
                    usum_next = '0;
                    prev_next = '0;
                    if (!init_reg)
                    begin
                        cnt_next = CW'(1);
                    end
                end
            end
            S_RD:
            begin
                // Memory read of idx is in flight.
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                // rd holds entry idx.
                if (cmd_reg == ffba_pkg::CMD_ALLOC)
                begin
                    if (!rd.used && rd.size >= want_reg)
                    begin
                        raddr_next = rd.start;
                        hit_next = idx_reg;
                        we = 1'b1;
                        wdata = '{start: rd.start, size: rd.size, used: 1'b1};
                        if (rd.size == want_reg || cnt_reg >= CW'(ffba_pkg::MaxRegions))
                        begin
                            idx_next = '0;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            // Remainder written after shifting up.
                            wdata.size = want_reg;
                            add_a = rd.start;
                            add_b = want_reg;
                            hold_next = '{start: add_y, size: rd.size - want_reg,
                                          used: 1'b0};
                            idx_next = IW'(cnt_reg - CW'(1));
                            lim_next = cnt_reg;
                            state_next = (IW'(cnt_reg - CW'(1)) == idx_reg) ?
                                         S_SHUPW : S_SHUP;
                        end
                    end
                    else if ({1'b0, idx_reg} + CW'(1) >= cnt_reg)
                    begin
                        st_next = ffba_pkg::ST_NOMEM;
                        idx_next = '0;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        prev_next = rd;
                        idx_next = idx_reg + IW'(1);
                        raddr = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (rd.start == addr_reg)
                    begin
                        hit_next = idx_reg;
                        if (!rd.used)
                        begin
                            st_next = ffba_pkg::ST_DOUBLE;
                            idx_next = '0;
                            state_next = S_STAT;
                        end
                        else
                        begin
                            mergeprev_next = (idx_reg != '0) && !prev_reg.used;
                            acc_next = rd.size;
                            hold_next = '{start: rd.start, size: rd.size, used: 1'b0};
                            if ({1'b0, idx_reg} + CW'(1) < cnt_reg)
                            begin
                                idx_next = idx_reg + IW'(1);
                                raddr = idx_reg + IW'(1);
                                state_next = S_FREE2;
                            end
                            else
                            begin
                                // No next entry, so nothing merges from above.
                                lim_next = '1;
                                state_next = S_FREE3;
                            end
                        end
                    end
                    else if ({1'b0, idx_reg} + CW'(1) >= cnt_reg)
                    begin
                        st_next = ffba_pkg::ST_UNKNOWN;
                        idx_next = '0;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        prev_next = rd;
                        idx_next = idx_reg + IW'(1);
                        raddr = idx_reg + IW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_SHUP:
            begin
                // Read of idx in flight; move it up one place next.
                state_next = S_SHUPW;
            end
            S_SHUPW:
            begin
                if (idx_reg == hit_reg)
                begin
                    we = 1'b1;
                    waddr = hit_reg + IW'(1);
                    wdata = hold_reg;
                    cnt_next = cnt_reg + CW'(1);
                    idx_next = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    we = 1'b1;
                    waddr = idx_reg + IW'(1);
                    wdata = rd;
                    idx_next = idx_reg - IW'(1);
                    raddr = idx_reg - IW'(1);
                    state_next = (idx_reg - IW'(1) == hit_reg) ? S_SHUPW : S_SHUP;
                end
            end
            S_FREE2:
            begin
                state_next = S_FREE4;
            end
            S_FREE4:
            begin
                // rd holds the next entry.
                if (!rd.used)
                begin
                    acc_next = add_y;
                    hold_next.size = add_y;
                    lim_next = CW'(idx_reg);  // drop this entry
                end
                else
                begin
                    lim_next = '1;
                end
                state_next = S_FREE3;
            end
            S_FREE3:
            begin
                // Write the merged entry and pick the entry to drop.
                if (mergeprev_reg)
                begin
                    we = 1'b1;
                    waddr = hit_reg - IW'(1);
                    wdata = '{start: prev_reg.start,
                              size: prev_reg.size + acc_reg, used: 1'b0};
                    if (lim_reg == '1 || lim_reg == '0 || lim_reg != CW'(hit_reg + IW'(1)))
                    begin
                        // only this entry drops
                        idx_next = hit_reg;
                        lim_next = CW'(1);
                    end
                    else
                    begin
                        idx_next = hit_reg;
                        lim_next = CW'(2);
                    end
                end
                else
                begin
                    we = 1'b1;
                    waddr = hit_reg;
                    wdata = hold_reg;
                    idx_next = hit_reg + IW'(1);
                    lim_next = (lim_reg == CW'(hit_reg + IW'(1)) && lim_reg != '0)
                               ? CW'(1) : CW'(0);
                    if (!(lim_reg == CW'(hit_reg + IW'(1)) && lim_reg != '0))
                    begin
                        lim_next = '0;
                    end
                end
                if (lim_next == '0)
                begin
                    idx_next = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    cnt_next = cnt_reg - lim_next;
                    raddr = idx_next + IW'(lim_next);
                    state_next = ({1'b0, idx_next} >= cnt_reg - lim_next) ?
                                 S_STAT : S_SHDN;
                    if (state_next == S_STAT)
                    begin
                        idx_next = '0;
                    end
                end
            end
            S_SHDN:
            begin
                // Read of idx+lim in flight.
                raddr = idx_reg + IW'(lim_reg);
                state_next = S_SHDNW;
            end
            S_SHDNW:
            begin
                we = 1'b1;
                waddr = idx_reg;
                wdata = rd;
                idx_next = idx_reg + IW'(1);
                raddr = idx_reg + IW'(1) + IW'(lim_reg);
                if ({1'b0, idx_reg} + CW'(1) >= cnt_reg)
                begin
                    idx_next = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_SHDN;
                end
            end
            S_STAT:
            begin
                raddr = idx_reg;
                state_next = S_STATW;
            end
            S_STATW:
            begin
                // Accumulate one entry per visit with the shared adder.
                add_a = rd.used ? usum_reg : fsum_reg;
                if (rd.used)
                begin
                    usum_next = add_y;
                end
                else
                begin
                    fsum_next = add_y;
                end
                idx_next = idx_reg + IW'(1);
                raddr = idx_reg + IW'(1);
                state_next = ({1'b0, idx_reg} + CW'(1) >= cnt_reg) ? S_DONE : S_STATW;
                if (state_next == S_STATW)
                begin
                    state_next = S_STAT;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command intake and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            init_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == S_IDLE && start)
            begin
                init_reg <= 1'b1;
            end
        end
    end

    // Payload registers of the command in progress.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        lim_reg <= lim_next;
        raddr_reg <= raddr_next;
        st_reg <= st_next;
        fsum_reg <= fsum_next;
        usum_reg <= usum_next;
        acc_reg <= acc_next;
        mergeprev_reg <= mergeprev_next;
        prev_reg <= prev_next;
        hold_reg <= hold_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= command;
            want_reg <= want_w[31:0];
            addr_reg <= block_address;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;
    assign result_address = (st_reg == ffba_pkg::ST_OK && cmd_reg == ffba_pkg::CMD_ALLOC)
                            ? raddr_reg : 32'd0;
    assign status = st_reg;
    assign free_total = fsum_reg;
    assign used_total = usum_reg;
    assign block_count = 7'(cnt_reg);

endmodule

// ===== rtl/ffba_table.sv =====
// Region table memory: one write port and one registered read port.
// Depends on ffba_pkg.
module ffba_table (
    input  logic clk,
    input  logic we,
    input  logic [ffba_pkg::IdxW-1:0] waddr,
    input  ffba_pkg::region_t wdata,
    input  logic [ffba_pkg::IdxW-1:0] raddr,
    output ffba_pkg::region_t rdata
);

    ffba_pkg::region_t mem [ffba_pkg::MaxRegions];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== verif/tb_first_fit_block_allocator_core.sv =====
// Self-checking testbench for the first-fit block allocator core.
// Depends on ffba_pkg and first_fit_block_allocator_core; reads no files.
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_core;

    localparam int TableDepth = ffba_pkg::MaxRegions;
    localparam int AlignBytes = ffba_pkg::Alignment;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [31:0] request_size;
    logic [31:0] block_address;
    logic        done;
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] free_total;
    logic [31:0] used_total;
    logic [6:0]  block_count;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  stat;
        logic [31:0] free_sum;
        logic [31:0] used_sum;
        logic [6:0]  count;
    } outcome_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] size;
        logic [31:0] baddr;
        bit          has_fixed;
        outcome_t    fixed;
    } stim_row_t;

    // Shadow copy of the allocator state.
    logic [31:0] shadow_start [TableDepth];
    logic [31:0] shadow_size  [TableDepth];
    bit          shadow_used  [TableDepth];
    int          shadow_count;
    bit          shadow_loaded;
    logic [31:0] shadow_heap_start;
    logic [31:0] shadow_heap_end;

    outcome_t    pending_outcomes [$];
    logic [31:0] live_blocks [$];
    int          mismatch_count;
    bit          in_tail;

    first_fit_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .command(command),
        .request_size(request_size), .block_address(block_address), .done(done),
        .result_address(result_address), .status(status), .free_total(free_total),
        .used_total(used_total), .block_count(block_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Remove entry i, shifting the tail down.
    function automatic void shadow_drop(int i);
        for (int k = i; k + 1 < shadow_count; k++)
        begin
            shadow_start[k] = shadow_start[k + 1];
            shadow_size[k]  = shadow_size[k + 1];
            shadow_used[k]  = shadow_used[k + 1];
        end
        shadow_count--;
    endfunction

    // Apply one command to the shadow table and return its result beat.
    function automatic outcome_t allocator_step(logic [1:0] cmd, logic [31:0] size,
                                                logic [31:0] baddr);
        outcome_t   o;
        logic [32:0] rounded;
        logic [31:0] want;
        bit          found;
        o = '0;
        if (!shadow_loaded)
        begin
            rounded = ({1'b0, shadow_heap_start} + AlignBytes - 1) & ~33'(AlignBytes - 1);
            shadow_start[0] = rounded[31:0];
            shadow_size[0]  = (shadow_heap_end >= rounded[31:0]) ?
                              shadow_heap_end - rounded[31:0] : 32'd0;
            shadow_used[0]  = 1'b0;
            shadow_count    = 1;
            shadow_loaded   = 1'b1;
        end
        if (cmd == ffba_pkg::CMD_ALLOC)
        begin
            rounded = ({1'b0, size} + AlignBytes - 1) & ~33'(AlignBytes - 1);
            if (size == 0)
                o.stat = ffba_pkg::ST_ZERO;
            else if (rounded[32])
                o.stat = ffba_pkg::ST_OVERFLOW;
            else
            begin
                want  = rounded[31:0];
                found = 1'b0;
                for (int i = 0; i < shadow_count && !found; i++)
                begin
                    if (!shadow_used[i] && shadow_size[i] >= want)
                    begin
                        found = 1'b1;
                        o.addr = shadow_start[i];
                        shadow_used[i] = 1'b1;
                        if (shadow_size[i] != want && shadow_count < TableDepth)
                        begin
                            for (int k = shadow_count; k > i + 1; k--)
                            begin
                                shadow_start[k] = shadow_start[k - 1];
                                shadow_size[k]  = shadow_size[k - 1];
                                shadow_used[k]  = shadow_used[k - 1];
                            end
                            shadow_count++;
                            shadow_start[i + 1] = shadow_start[i] + want;
                            shadow_size[i + 1]  = shadow_size[i] - want;
                            shadow_used[i + 1]  = 1'b0;
                            shadow_size[i]      = want;
                        end
                    end
                end
                o.stat = found ? ffba_pkg::ST_OK : ffba_pkg::ST_NOMEM;
            end
        end
        else if (cmd == ffba_pkg::CMD_FREE && baddr != 0)
        begin
            o.stat = ffba_pkg::ST_UNKNOWN;
            for (int i = 0; i < shadow_count; i++)
            begin
                if (shadow_start[i] == baddr)
                begin
                    if (!shadow_used[i])
                        o.stat = ffba_pkg::ST_DOUBLE;
                    else
                    begin
                        o.stat = ffba_pkg::ST_OK;
                        shadow_used[i] = 1'b0;
                        if (i + 1 < shadow_count && !shadow_used[i + 1])
                        begin
                            shadow_size[i] += shadow_size[i + 1];
                            shadow_drop(i + 1);
                        end
                        if (i > 0 && !shadow_used[i - 1])
                        begin
                            shadow_size[i - 1] += shadow_size[i];
                            shadow_drop(i);
                        end
                    end
                    break;
                end
            end
        end
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_used[i])
                o.used_sum += shadow_size[i];
            else
                o.free_sum += shadow_size[i];
        end
        o.count = 7'(shadow_count);
        return o;
    endfunction

    // Check every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t seen;
        outcome_t want;
        if (rst_n && done)
        begin
            seen = '{result_address, status, free_total, used_total, block_count};
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %p", seen);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, got %p", want, seen);
                end
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // Drive one command beat and record its expectation.
    task automatic issue_command(logic [1:0] cmd, logic [31:0] size, logic [31:0] baddr,
                                 bit has_fixed = 0, outcome_t fixed = '0);
        outcome_t o;
        if (!in_tail && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 9));
        start         <= 1'b1;
        command       <= cmd;
        request_size  <= size;
        block_address <= baddr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        o = allocator_step(cmd, size, baddr);
        if (has_fixed)
        begin
            if (o !== fixed)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("table row disagrees: typed %p, predicted %p", fixed, o);
            end
        end
        pending_outcomes.push_back(o);
        if (cmd == ffba_pkg::CMD_ALLOC && o.stat == ffba_pkg::ST_OK)
            live_blocks.push_back(o.addr);
        start <= 1'b0;
        // Wait for the busy that follows acceptance to drop.
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (pending_outcomes.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        idle_cycles(20);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(logic idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ffba_pkg::REG_HEAP_START)
            shadow_heap_start = value;
        else
            shadow_heap_end = value;
    endtask

    // Reset the shadow alongside the block; only the first reset touches the RTL.
    task automatic fresh_heap_shadow();
        shadow_count  = 0;
        shadow_loaded = 1'b0;
        live_blocks.delete();
    endtask

    function automatic logic [31:0] random_size();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'(1) << $urandom_range(0, 31);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // One random command, mostly well-formed alloc/free traffic.
    task automatic random_command();
        int pick;
        int j;
        logic [31:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            issue_command(ffba_pkg::CMD_ALLOC, random_size(), $urandom());
        else if (pick < 80 && live_blocks.size() != 0)
        begin
            j = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[j];
            live_blocks.delete(j);
            issue_command(ffba_pkg::CMD_FREE, $urandom(), a);
        end
        else if (pick < 88)
            issue_command(ffba_pkg::CMD_FREE, $urandom(),
                          $urandom_range(0, 1) ? $urandom() : 32'h4000_0000);
        else if (pick < 94)
            issue_command(ffba_pkg::CMD_STATS, $urandom(), $urandom());
        else
            issue_command(ffba_pkg::CMD_SPARE, $urandom(), $urandom());
    endtask

    stim_row_t directed_rows [$];

    initial
    begin
        stim_row_t r;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        start = 1'b0; command = '0; request_size = '0; block_address = '0;
        mismatch_count = 0;
        in_tail = 1'b0;
        shadow_heap_start = 32'h4000_0000;
        shadow_heap_end   = 32'h5000_0000;
        fresh_heap_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset heap, extremes, every error code.
        directed_rows = '{
            '{ffba_pkg::CMD_STATS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              '{32'd0, ffba_pkg::ST_OK, 32'h1000_0000, 32'd0, 7'd1}},
            '{ffba_pkg::CMD_ALLOC, 32'd0, 32'd0, 1,
              '{32'd0, ffba_pkg::ST_ZERO, 32'h1000_0000, 32'd0, 7'd1}},
            '{ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 1,
              '{32'd0, ffba_pkg::ST_OVERFLOW, 32'h1000_0000, 32'd0, 7'd1}},
            '{ffba_pkg::CMD_ALLOC, 32'hFFFF_FFF8, 32'd0, 1,
              '{32'd0, ffba_pkg::ST_NOMEM, 32'h1000_0000, 32'd0, 7'd1}},
            '{ffba_pkg::CMD_ALLOC, 32'd1, 32'd0, 1,
              '{32'h4000_0000, ffba_pkg::ST_OK, 32'h0FFF_FFF8, 32'd8, 7'd2}},
            '{ffba_pkg::CMD_ALLOC, 32'd100, 32'd0, 0, '0},
            '{ffba_pkg::CMD_ALLOC, 32'd8, 32'd0, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'd0, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h1234_5677, 1,
              '{32'd0, ffba_pkg::ST_UNKNOWN, 32'h0FFF_FF88, 32'd120, 7'd4}},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h4000_0008, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h4000_0008, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h4000_0000, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h4000_0070, 0, '0},
            '{ffba_pkg::CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
            '{ffba_pkg::CMD_ALLOC, 32'h1000_0000, 32'd0, 0, '0},
            '{ffba_pkg::CMD_FREE, 32'd0, 32'h4000_0000, 0, '0}
        };
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            issue_command(r.cmd, r.size, r.baddr, r.has_fixed, r.fixed);
        end
        drain_results();

        // Later register writes must not reload the heap.
        write_register(ffba_pkg::REG_HEAP_START, 32'hFFFF_FFFF);
        write_register(ffba_pkg::REG_HEAP_END, 32'h0000_0000);
        issue_command(ffba_pkg::CMD_STATS, 32'd0, 32'd0);
        repeat (150) random_command();
        drain_results();

        // Fill the table to force whole-region handover.
        for (int i = 0; i < 70; i++)
            issue_command(ffba_pkg::CMD_ALLOC, $urandom_range(1, 64), 32'd0);
        repeat (100) random_command();
        repeat (100) random_command();
        drain_results();

        // Closing churn; the last hundred commands run with no idle gaps.
        for (int i = 0; i < 500; i++)
        begin
            if (i == 400)
                in_tail = 1'b1;
            random_command();
        end
        drain_results();

        if (pending_outcomes.size() == 0 && mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
